// File: rtl/deadline_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// deadline timer queue assertion macros
// concurrent check wrappers, clocked on clock; DTQ_ASSERT is masked during reset
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DTQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("deadline_timer_queue check failed");

`define DTQ_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("deadline_timer_queue check failed");

`else

`define DTQ_ASSERT(label, prop)

`define DTQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and codes of the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam logic CMD_ARM  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic REG_WAKEUP_RES = 1'b0;
   localparam logic REG_BUSY_THR   = 1'b1;

   localparam logic [15:0] WAKEUP_RES_RESET = 16'd50;
   localparam logic [15:0] BUSY_THR_RESET   = 16'd1000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARM,
      ST_TICK
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [7:0]  key_tag;
   } cell_ctl_type;

   typedef struct packed {
      logic        command;
      logic [31:0] time_now;
      logic [23:0] delay;
      logic [7:0]  tag;
   } req_payload_type;

   typedef struct packed {
      logic        expired_valid;
      logic [7:0]  expired_tag;
      logic        last;
      logic        arm_full;
      logic [15:0] sleep_time;
      logic        busy_wait;
      logic        queue_empty;
   } rsp_payload_type;

endpackage

// File: rtl/dtq_stream_if.sv
// ----------------------------------------------------------------------------
// dtq_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface dtq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// one slot of the sorted timer chain; takes a new key, shifts right on
// insert or shifts left on pop
// ----------------------------------------------------------------------------
module dtq_cell #(
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtq_pkg::cell_ctl_type ctl,
   input  logic [TIME_BITS-1:0]  key_deadline,
   input  logic                  left_valid,
   input  logic [TIME_BITS-1:0]  left_deadline,
   input  logic [7:0]            left_tag,
   input  logic                  left_gt,
   input  logic                  right_valid,
   input  logic [TIME_BITS-1:0]  right_deadline,
   input  logic [7:0]            right_tag,
   output logic                  cell_valid,
   output logic [TIME_BITS-1:0]  cell_deadline,
   output logic [7:0]            cell_tag,
   output logic                  cell_gt
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [TIME_BITS-1:0] deadline_ff;
   logic [TIME_BITS-1:0] deadline_in;
   logic [7:0]           tag_ff;
   logic [7:0]           tag_in;
   logic                 own_gt;

   // later deadlines move aside so equal keys keep arrival order
   assign own_gt = !valid_ff || (deadline_ff > key_deadline);

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      tag_in      = tag_ff;
      case (ctl.op)
         dtq_pkg::CELL_INSERT: begin
            if (own_gt) begin
               if (left_gt) begin
                  valid_in    = left_valid;
                  deadline_in = left_deadline;
                  tag_in      = left_tag;
               end else begin
                  valid_in    = 1'b1;
                  deadline_in = key_deadline;
                  tag_in      = ctl.key_tag;
               end
            end
         end
         dtq_pkg::CELL_POP: begin
            valid_in    = right_valid;
            deadline_in = right_deadline;
            tag_in      = right_tag;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      tag_ff      <= tag_in;
   end

   assign cell_valid    = valid_ff;
   assign cell_deadline = deadline_ff;
   assign cell_tag      = tag_ff;
   assign cell_gt       = own_gt;

endmodule

// File: rtl/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// one-shot timer queue ordered by deadline
//
// Timers sit in a chain of CAPACITY cells kept sorted by deadline, earliest
// in the first cell; equal deadlines leave in the order they were armed. An
// arm transfer takes the request and registers the saturated deadline, then
// inserts it into the chain in place and posts the result once the result
// register is free. A tick transfer pops one expired timer from the chain
// head and posts its result per cycle while the result register is free, or
// posts one result if none expired. A new request is taken only once
// the previous one has posted its last result, but a posted result may still
// be waiting on the response side. Configuration writes go through the APB
// port at byte addresses 0 (wakeup resolution) and 4 (busy-wait threshold).
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_assert.svh"

module deadline_timer_queue #(
   parameter int CAPACITY  = 64,
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   dtq_stream_if.sink   req_bus,
   dtq_stream_if.source rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int SUM_BITS = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
   localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

   dtq_pkg::state_type state_ff;
   dtq_pkg::state_type state_in;

   logic [15:0] wakeup_res_ff;
   logic [15:0] busy_thr_ff;

   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] deadline_ff;
   logic [7:0]           tag_ff;
   logic [TIME_BITS-1:0] now_in;
   logic [TIME_BITS-1:0] deadline_in;
   logic [SUM_BITS-1:0]  sum;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   dtq_pkg::rsp_payload_type rsp_ff;
   dtq_pkg::rsp_payload_type rsp_in;

   dtq_pkg::cell_ctl_type ctl;
   logic                  req_take;
   logic                  slot_free;
   logic                  csr_write;

   logic                 link_valid    [0:CAPACITY+1];
   logic [TIME_BITS-1:0] link_deadline [0:CAPACITY+1];
   logic [7:0]           link_tag      [0:CAPACITY+1];
   logic                 link_gt       [0:CAPACITY];
   logic [CAPACITY-1:0]  valid_vec;

   logic                 head_exp;
   logic                 next_exp;
   logic                 tick_last;
   logic                 sel_valid;
   logic [TIME_BITS-1:0] sel_deadline;
   logic [TIME_BITS-1:0] gap;
   logic [15:0]          sleep;

   // configuration
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == dtq_pkg::REG_WAKEUP_RES) ? {16'd0, wakeup_res_ff}
                                                            : {16'd0, busy_thr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wakeup_res_ff <= dtq_pkg::WAKEUP_RES_RESET;
         busy_thr_ff   <= dtq_pkg::BUSY_THR_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            dtq_pkg::REG_WAKEUP_RES: wakeup_res_ff <= pwdata[15:0];
            dtq_pkg::REG_BUSY_THR:   busy_thr_ff   <= pwdata[15:0];
            default:                 wakeup_res_ff <= wakeup_res_ff;
         endcase
      end
   end

   // request capture with saturated deadline
   assign req_bus.ready = (state_ff == dtq_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign now_in        = TIME_BITS'(req_bus.payload.time_now);
   assign sum           = SUM_BITS'(now_in) + SUM_BITS'(req_bus.payload.delay);
   assign deadline_in   = (sum > SUM_BITS'(TIME_MASK)) ? TIME_MASK : sum[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff      <= now_in;
         deadline_ff <= deadline_in;
         tag_ff      <= req_bus.payload.tag;
      end
   end

   // cell chain; link index i+1 is cell i, the two ends are empty
   assign link_valid[0]               = 1'b0;
   assign link_deadline[0]            = '0;
   assign link_tag[0]                 = '0;
   assign link_gt[0]                  = 1'b0;
   assign link_valid[CAPACITY+1]      = 1'b0;
   assign link_deadline[CAPACITY+1]   = '0;
   assign link_tag[CAPACITY+1]        = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      dtq_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .key_deadline   (deadline_ff),
         .left_valid     (link_valid[i]),
         .left_deadline  (link_deadline[i]),
         .left_tag       (link_tag[i]),
         .left_gt        (link_gt[i]),
         .right_valid    (link_valid[i+2]),
         .right_deadline (link_deadline[i+2]),
         .right_tag      (link_tag[i+2]),
         .cell_valid     (link_valid[i+1]),
         .cell_deadline  (link_deadline[i+1]),
         .cell_tag       (link_tag[i+1]),
         .cell_gt        (link_gt[i+1])
      );
      assign valid_vec[i] = link_valid[i+1];
   end

   // head of the chain and sleep time
   assign slot_free    = !rsp_valid_ff || rsp_bus.ready;
   assign head_exp     = link_valid[1] && (link_deadline[1] <= now_ff);
   assign next_exp     = link_valid[2] && (link_deadline[2] <= now_ff);
   assign tick_last    = !(head_exp && next_exp);
   assign sel_valid    = head_exp ? link_valid[2] : link_valid[1];
   assign sel_deadline = head_exp ? link_deadline[2] : link_deadline[1];
   assign gap          = sel_deadline - now_ff;
   assign sleep        = (sel_valid && (gap < TIME_BITS'(wakeup_res_ff))) ? gap[15:0]
                                                                          : wakeup_res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (req_bus.payload.command == dtq_pkg::CMD_TICK) ? dtq_pkg::ST_TICK
                                                                         : dtq_pkg::ST_ARM;
            end
         end
         dtq_pkg::ST_ARM: begin
            if (slot_free) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         dtq_pkg::ST_TICK: begin
            if (slot_free && tick_last) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl.op       = dtq_pkg::CELL_HOLD;
      ctl.key_tag  = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         dtq_pkg::ST_ARM: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.last            = 1'b1;
               rsp_in.arm_full        = link_valid[CAPACITY];
               if (!link_valid[CAPACITY]) begin
                  ctl.op = dtq_pkg::CELL_INSERT;
               end
            end
         end
         dtq_pkg::ST_TICK: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.expired_valid = head_exp;
               rsp_in.expired_tag   = head_exp ? link_tag[1] : 8'd0;
               rsp_in.last          = tick_last;
               if (tick_last) begin
                  rsp_in.sleep_time  = sleep;
                  rsp_in.busy_wait   = sleep < busy_thr_ff;
                  rsp_in.queue_empty = !sel_valid;
               end
               if (head_exp) begin
                  ctl.op = dtq_pkg::CELL_POP;
               end
            end
         end
         default: begin
            ctl.op = dtq_pkg::CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // checks
   `DTQ_ASSERT(a_chain_packed, $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
   `DTQ_ASSERT(a_head_sorted, (link_valid[2] |-> (link_deadline[1] <= link_deadline[2])))
   `DTQ_ASSERT(a_mid_result_expired, ((rsp_valid_ff && !rsp_ff.last) |-> rsp_ff.expired_valid))
   `DTQ_ASSERT(a_full_held, ((rsp_valid_ff && rsp_ff.arm_full) |-> link_valid[CAPACITY]))

endmodule

// File: dv/deadline_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// self-checking bench for the deadline ordered timer queue
//
// Arm and tick requests go in on the request stream. An in-bench copy of the
// sorted timer store predicts the expected results. The bench walks through
// edge values, equal deadlines, saturation, a full store and random traffic
// under several register settings. Both streams idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue_tb;

   localparam int MAX_TIMERS  = 64;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_PRINTS  = 60;

   logic clock = 1'b0;
   logic reset;

   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dtq_stream_if #(.payload_type(dtq_pkg::req_payload_type)) req_if ();
   dtq_stream_if #(.payload_type(dtq_pkg::rsp_payload_type)) rsp_if ();

   deadline_timer_queue #(
      .CAPACITY (MAX_TIMERS),
      .TIME_BITS(32)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted timer store and register copies
   logic [31:0]              timer_deadline [MAX_TIMERS];
   logic [7:0]               timer_tag      [MAX_TIMERS];
   int                       timer_count;
   logic [15:0]              wake_resolution;
   logic [15:0]              busy_threshold;
   dtq_pkg::rsp_payload_type pending_results [$];

   int          error_count;
   int          stall_cycles;
   logic        no_idle;
   logic [31:0] now_us;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS)
         $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void expect_result(input dtq_pkg::rsp_payload_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_request(input dtq_pkg::req_payload_type item);
      dtq_pkg::rsp_payload_type r;
      logic [32:0]     sum;
      logic [31:0]     dl;
      logic [31:0]     gap;
      logic [15:0]     sleep;
      logic [7:0]      fired_tag [MAX_TIMERS];
      int              pos;
      int              fired;
      r = '0;
      if (item.command == dtq_pkg::CMD_ARM) begin
         r.last = 1'b1;
         if (timer_count >= MAX_TIMERS) begin
            r.arm_full    = 1'b1;
            r.queue_empty = (timer_count == 0);
         end else begin
            sum = {1'b0, item.time_now} + {9'd0, item.delay};
            dl  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            pos = timer_count;
            while (pos > 0 && timer_deadline[pos-1] > dl) begin
               timer_deadline[pos] = timer_deadline[pos-1];
               timer_tag[pos]      = timer_tag[pos-1];
               pos--;
            end
            timer_deadline[pos] = dl;
            timer_tag[pos]      = item.tag;
            timer_count++;
         end
         expect_result(r);
      end else begin
         fired = 0;
         while (fired < timer_count && timer_deadline[fired] <= item.time_now) begin
            fired_tag[fired] = timer_tag[fired];
            fired++;
         end
         for (int i = 0; i < timer_count - fired; i++) begin
            timer_deadline[i] = timer_deadline[i+fired];
            timer_tag[i]      = timer_tag[i+fired];
         end
         timer_count = timer_count - fired;
         sleep = wake_resolution;
         if (timer_count > 0) begin
            gap = timer_deadline[0] - item.time_now;
            if (gap < {16'd0, wake_resolution})
               sleep = gap[15:0];
         end
         for (int i = 0; i < fired; i++) begin
            r = '0;
            r.expired_valid = 1'b1;
            r.expired_tag   = fired_tag[i];
            if (i == fired - 1) begin
               r.last        = 1'b1;
               r.sleep_time  = sleep;
               r.busy_wait   = (sleep < busy_threshold);
               r.queue_empty = (timer_count == 0);
            end
            expect_result(r);
         end
         if (fired == 0) begin
            r.last        = 1'b1;
            r.sleep_time  = sleep;
            r.busy_wait   = (sleep < busy_threshold);
            r.queue_empty = (timer_count == 0);
            expect_result(r);
         end
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_results
      dtq_pkg::rsp_payload_type got;
      dtq_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(got), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (got.expired_valid !== want.expired_valid)
               report_mismatch("expired_valid", 32'(got.expired_valid),
                               32'(want.expired_valid));
            if (got.expired_tag !== want.expired_tag)
               report_mismatch("expired_tag", 32'(got.expired_tag), 32'(want.expired_tag));
            if (got.last !== want.last)
               report_mismatch("last", 32'(got.last), 32'(want.last));
            if (got.arm_full !== want.arm_full)
               report_mismatch("arm_full", 32'(got.arm_full), 32'(want.arm_full));
            if (got.sleep_time !== want.sleep_time)
               report_mismatch("sleep_time", 32'(got.sleep_time), 32'(want.sleep_time));
            if (got.busy_wait !== want.busy_wait)
               report_mismatch("busy_wait", 32'(got.busy_wait), 32'(want.busy_wait));
            if (got.queue_empty !== want.queue_empty)
               report_mismatch("queue_empty", 32'(got.queue_empty), 32'(want.queue_empty));
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 24);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[deadline_timer_queue] ERROR");
         $finish;
      end
   end

   task automatic send_request(input dtq_pkg::req_payload_type item);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_request(item);
   endtask

   task automatic arm_timer(input logic [31:0] at, input logic [23:0] delay,
                            input logic [7:0] tag);
      dtq_pkg::req_payload_type item;
      item.command  = dtq_pkg::CMD_ARM;
      item.time_now = at;
      item.delay    = delay;
      item.tag      = tag;
      send_request(item);
   endtask

   task automatic tick_at(input logic [31:0] at);
      dtq_pkg::req_payload_type item;
      item.command  = dtq_pkg::CMD_TICK;
      item.time_now = at;
      item.delay    = 24'( 32'($urandom));
      item.tag      = 8'($urandom);
      send_request(item);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {index, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      logic [31:0] readback;
      wait_drained();
      repeat (4) @(posedge clock);
      csr_access(1'b1, index, {16'd0, value}, readback);
      csr_access(1'b0, index, 32'd0, readback);
      if (index == dtq_pkg::REG_WAKEUP_RES)
         wake_resolution = value;
      else
         busy_threshold = value;
      if (readback[15:0] !== value)
         report_mismatch("register readback", readback, {16'd0, value});
   endtask

   task automatic test_register_reset();
      logic [31:0] readback;
      csr_access(1'b0, dtq_pkg::REG_WAKEUP_RES, 32'd0, readback);
      if (readback[15:0] !== dtq_pkg::WAKEUP_RES_RESET)
         report_mismatch("wakeup resolution reset", readback,
                         32'(dtq_pkg::WAKEUP_RES_RESET));
      csr_access(1'b0, dtq_pkg::REG_BUSY_THR, 32'd0, readback);
      if (readback[15:0] !== dtq_pkg::BUSY_THR_RESET)
         report_mismatch("busy threshold reset", readback, 32'(dtq_pkg::BUSY_THR_RESET));
   endtask

   task automatic test_directed_edges();
      tick_at(32'd0);
      arm_timer(32'd0, 24'd0, 8'h00);
      tick_at(32'd0);
      // saturated deadlines, equal ones leave in arm order
      arm_timer(32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
      arm_timer(32'hFFFF_FFF0, 24'h00_0020, 8'hA5);
      arm_timer(32'hFFFF_FF00, 24'h00_0010, 8'h5A);
      tick_at(32'hFFFF_FF00);
      tick_at(32'hFFFF_FFFF);
      arm_timer(32'd1000, 24'd500, 8'h11);
      arm_timer(32'd1000, 24'd500, 8'h22);
      arm_timer(32'd1000, 24'd500, 8'h33);
      arm_timer(32'd1000, 24'd100, 8'h44);
      tick_at(32'd1099);
      tick_at(32'd1100);
      // zero resolution
      write_register(dtq_pkg::REG_WAKEUP_RES, 16'd0);
      tick_at(32'd1200);
      tick_at(32'd1600);
      // gap equal to the resolution, above the threshold
      write_register(dtq_pkg::REG_WAKEUP_RES, 16'd2000);
      arm_timer(32'd0, 24'd5000, 8'h77);
      tick_at(32'd3000);
      tick_at(32'd5000);
      write_register(dtq_pkg::REG_WAKEUP_RES, dtq_pkg::WAKEUP_RES_RESET);
   endtask

   task automatic test_store_full();
      for (int i = 0; i < MAX_TIMERS + 2; i++)
         arm_timer(32'd10000, 24'($urandom_range(0, 200)), 8'($urandom));
      tick_at(32'd11000);
   endtask

   task automatic test_random_traffic(input int count);
      int pick;
      dtq_pkg::req_payload_type item;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            item.command  = 1'($urandom);
            item.time_now = $urandom;
            item.delay    = 24'($urandom);
            item.tag      = 8'($urandom);
            send_request(item);
         end else if (pick < 60) begin
            pick = $urandom_range(99);
            if (pick < 3)
               arm_timer(now_us, 24'($urandom), 8'($urandom));
            else if (pick < 15)
               arm_timer(now_us, 24'($urandom_range(0, 70000)), 8'($urandom));
            else
               arm_timer(now_us, 24'($urandom_range(0, 400)), 8'($urandom));
         end else begin
            now_us = now_us + $urandom_range(0, 150);
            tick_at(now_us);
         end
      end
   endtask

   task automatic test_tight_config();
      write_register(dtq_pkg::REG_WAKEUP_RES, 16'd1);
      write_register(dtq_pkg::REG_BUSY_THR, 16'd0);
      no_idle = 1'b1;
      test_random_traffic(50);
      no_idle = 1'b0;
   endtask

   task automatic test_wide_config();
      write_register(dtq_pkg::REG_WAKEUP_RES, 16'hFFFF);
      write_register(dtq_pkg::REG_BUSY_THR, 16'hFFFF);
      test_random_traffic(50);
   endtask

   task automatic test_random_config();
      write_register(dtq_pkg::REG_WAKEUP_RES, 16'($urandom_range(1, 65535)));
      write_register(dtq_pkg::REG_BUSY_THR, 16'($urandom_range(0, 65535)));
      test_random_traffic(20);
      wait_drained();
      test_random_traffic(20);
   endtask

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_if.valid    = 1'b0;
      req_if.payload  = '0;
      rsp_if.ready    = 1'b0;
      timer_count     = 0;
      wake_resolution = dtq_pkg::WAKEUP_RES_RESET;
      busy_threshold  = dtq_pkg::BUSY_THR_RESET;
      error_count     = 0;
      stall_cycles    = 0;
      no_idle         = 1'b0;
      now_us          = 32'd20000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_directed_edges();
      test_store_full();
      test_random_traffic(40);
      test_tight_config();
      test_wide_config();
      test_random_config();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("[deadline_timer_queue] OK");
      else
         $display("[deadline_timer_queue] ERROR");
      $finish;
   end

endmodule
